// ----- rtl/double_ended_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shorthand for the clocked, reset-qualified checks on the queue ports.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("double_ended_queue check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("double_ended_queue check failed");

`endif

// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Request and status codes, port widths and the controller command type.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int REQ_W     = 3;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 40;

	localparam logic [REQ_W-1:0] REQ_PUSH_R = 3'd0;
	localparam logic [REQ_W-1:0] REQ_POP_L  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_R  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_PEEK_L = 3'd3;
	localparam logic [REQ_W-1:0] REQ_PEEK_R = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic accept;
		logic load;
	} cmd_t;

endpackage

// ----- rtl/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences each request through the store read and the output register.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output deq_pkg::cmd_t cmd
);
	import deq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_READ = 1'b1;

	logic state_q;
	logic state_nx;
	logic out_valid_q;
	logic can_load;
	logic accept;

	assign can_load   = (state_q == ST_READ) && (!out_valid_q || out_ready);
	assign in_ready   = (state_q == ST_IDLE) || can_load;
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign cmd.accept = accept;
	assign cmd.load   = can_load;

	always_comb begin
		priority if (accept) begin
			state_nx = ST_READ;
		end else if (can_load) begin
			state_nx = ST_IDLE;
		end else begin
			state_nx = state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/deq_datapath.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring pointers, word store with registered read, and the result registers.
// ----------------------------------------------------------------------------
module deq_datapath #(
	parameter int CAPACITY   = 256,
	parameter int WORD_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  deq_pkg::cmd_t                  cmd,
	input  logic [deq_pkg::REQ_W-1:0]      req_type,
	input  logic [deq_pkg::VALUE_W-1:0]    push_value,
	output logic [deq_pkg::VALUE_W-1:0]    item_value,
	output logic                           is_empty,
	output logic [deq_pkg::STATUS_W-1:0]   status
);
	import deq_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [IW:0]   CAP_W = (IW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	function automatic logic [IW-1:0] wrap(input logic [IW:0] s);
		logic [IW:0] r;
		r = (s >= CAP_W) ? (s - CAP_W) : s;
		return r[IW-1:0];
	endfunction

	logic [WORD_WIDTH-1:0] mem_q [CAPACITY];
	logic [WORD_WIDTH-1:0] rd_data_q;
	logic [IW-1:0]         left_q;
	logic [CW-1:0]         count_q;
	logic                  use_q;
	logic                  empty_q;
	logic [STATUS_W-1:0]   status_q;
	logic [VALUE_W-1:0]    out_value_q;
	logic                  out_empty_q;
	logic [STATUS_W-1:0]   out_status_q;

	logic                  is_push;
	logic                  is_left;
	logic                  is_right;
	logic                  is_pop;
	logic                  full;
	logic                  cnt_zero;
	logic [CW-1:0]         cnt_m1;
	logic [IW-1:0]         wr_addr;
	logic [IW-1:0]         rd_addr;
	logic [IW-1:0]         left_inc;
	logic [IW-1:0]         left_nx;
	logic [CW-1:0]         cnt_nx;
	logic [STATUS_W-1:0]   status_nx;
	logic                  use_nx;
	logic                  wr_en;
	logic                  rd_en;
	logic [WORD_WIDTH+VALUE_W-1:0] wr_ext;
	logic [WORD_WIDTH+VALUE_W-1:0] rd_ext;

	assign wr_ext = {{WORD_WIDTH{1'b0}}, push_value};
	assign rd_ext = {{VALUE_W{1'b0}}, rd_data_q};

	always_comb begin
		is_push  = (req_type == REQ_PUSH_R);
		is_left  = (req_type == REQ_POP_L) || (req_type == REQ_PEEK_L);
		is_right = (req_type == REQ_POP_R) || (req_type == REQ_PEEK_R);
		is_pop   = (req_type == REQ_POP_L) || (req_type == REQ_POP_R);
		full     = (count_q == CAP_C);
		cnt_zero = (count_q == '0);
		cnt_m1   = count_q - 1'b1;
		wr_addr  = wrap({1'b0, left_q} + {1'b0, count_q[IW-1:0]});
		left_inc = wrap({1'b0, left_q} + (IW + 1)'(1));
		rd_addr  = is_left ? left_q : wrap({1'b0, left_q} + {1'b0, cnt_m1[IW-1:0]});

		left_nx   = left_q;
		cnt_nx    = count_q;
		status_nx = STATUS_OK;
		use_nx    = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		priority if (is_push) begin
			if (full) begin
				status_nx = STATUS_FULL;
			end else begin
				wr_en  = cmd.accept;
				cnt_nx = count_q + 1'b1;
			end
		end else if (is_left || is_right) begin
			if (cnt_zero) begin
				status_nx = STATUS_EMPTY;
			end else begin
				rd_en  = cmd.accept;
				use_nx = 1'b1;
				if (is_pop) begin
					cnt_nx = cnt_m1;
				end
				if (req_type == REQ_POP_L) begin
					left_nx = left_inc;
				end
			end
		end else begin
			status_nx = STATUS_OK;
		end
		if (cnt_nx == '0) begin
			left_nx = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_ext[WORD_WIDTH-1:0];
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			left_q  <= left_nx;
			count_q <= cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			use_q    <= use_nx;
			empty_q  <= (cnt_nx == '0);
			status_q <= status_nx;
		end
		if (cmd.load) begin
			out_value_q  <= use_q ? rd_ext[VALUE_W-1:0] : '0;
			out_empty_q  <= empty_q;
			out_status_q <= status_q;
		end
	end

	assign item_value = out_value_q;
	assign is_empty   = out_empty_q;
	assign status     = out_status_q;

endmodule

// ----- rtl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue
// Fixed-capacity deque of words in a ring store with push, pop and peek.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser carries the request type and
// tdata the word to push. Each request returns exactly one item on the
// m_axis channel: tdata holds the word popped or peeked and the empty flag,
// tuser holds the status code.
// After acceptance the ring store is written or read, and the output register
// is then loaded from the registered read data once the register is free.
// A new request is taken in the same cycle that the previous result enters
// the output register, so the block sustains one item per cycle while the
// receiver keeps up.
// Reset empties the queue and drops any pending result; the store contents
// are left as they are.
// When the receiver stalls, the result waits in the output register; one
// more request may be accepted and then waits in the datapath until the
// output register is free.
// ----------------------------------------------------------------------------
module double_ended_queue #(
	parameter int CAPACITY   = 256,
	parameter int WORD_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [deq_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // push_value
	input  logic [deq_pkg::REQ_W-1:0]       s_axis_tuser,  // req_type
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [deq_pkg::M_TDATA_W-1:0]   m_axis_tdata,  // item_value, is_empty, zero pad
	output logic [deq_pkg::STATUS_W-1:0]    m_axis_tuser   // status
);
	import deq_pkg::*;

	cmd_t                cmd;
	logic [VALUE_W-1:0]  item_value;
	logic                is_empty;

	deq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	deq_datapath #(
		.CAPACITY   (CAPACITY),
		.WORD_WIDTH (WORD_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_type   (s_axis_tuser),
		.push_value (s_axis_tdata),
		.item_value (item_value),
		.is_empty   (is_empty),
		.status     (m_axis_tuser)
	);

	assign m_axis_tdata = {(M_TDATA_W - VALUE_W - 1)'(0), is_empty, item_value};

endmodule

// ----- rtl/deq_checker.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue port checker
// Checks the result channel of the queue over time and binds to the top.
// ----------------------------------------------------------------------------
`include "double_ended_queue_assert.svh"

module deq_port_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [deq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
	input  logic [deq_pkg::STATUS_W-1:0]    m_axis_tuser
);
	import deq_pkg::*;

	logic [STATUS_W+M_TDATA_W-1:0] out_bus;
	logic                          out_stall;
	logic                          status_known;
	logic                          full_seen;
	logic                          full_clean;
	logic                          empty_seen;
	logic                          empty_clean;

	assign out_bus      = {m_axis_tuser, m_axis_tdata};
	assign out_stall    = m_axis_tvalid && !m_axis_tready;
	assign status_known = (m_axis_tuser == STATUS_OK) || (m_axis_tuser == STATUS_EMPTY) ||
		(m_axis_tuser == STATUS_FULL);
	assign full_seen    = m_axis_tvalid && (m_axis_tuser == STATUS_FULL);
	assign full_clean   = !m_axis_tdata[VALUE_W] && (m_axis_tdata[VALUE_W-1:0] == '0);
	assign empty_seen   = m_axis_tvalid && (m_axis_tuser == STATUS_EMPTY);
	assign empty_clean  = m_axis_tdata[VALUE_W] && (m_axis_tdata[VALUE_W-1:0] == '0);

	`DEQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(out_bus))
	`DEQ_ASSERT_NOW(a_status_code, clk, arst_n, m_axis_tvalid, status_known)
	`DEQ_ASSERT_NOW(a_full_not_empty, clk, arst_n, full_seen, full_clean)
	`DEQ_ASSERT_NOW(a_empty_err, clk, arst_n, empty_seen, empty_clean)

endmodule

bind double_ended_queue deq_port_checker u_deq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ----- dv/deq_checker.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Watches both streams, keeps its own ring of words with a left index and an
// occupancy count, predicts the result of every accepted request and compares
// each returned item with the oldest prediction.
// ----------------------------------------------------------------------------
module deq_checker #(
	parameter int DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [deq_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic [deq_pkg::REQ_W-1:0]     s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [deq_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [deq_pkg::STATUS_W-1:0]  m_tuser,
	output int                            fail_count,
	output int                            pending,
	output int                            results_seen,
	output int                            empty_hits,
	output int                            full_hits
);

	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	typedef struct packed {
		logic [VALUE_W-1:0]  word;
		logic                empty;
		logic [STATUS_W-1:0] status;
	} deq_result_t;

	logic [VALUE_W-1:0] ring_words [DEPTH];
	logic [IDX_W-1:0]   head_idx;
	logic [IDX_W:0]     occupancy;
	deq_result_t        outstanding_q [$];

	initial begin
		fail_count   = 0;
		pending      = 0;
		results_seen = 0;
		empty_hits   = 0;
		full_hits    = 0;
	end

	task automatic apply_request(input logic [REQ_W-1:0] kind,
			input logic [VALUE_W-1:0] value, output deq_result_t res);
		res        = '0;
		res.status = STATUS_OK;
		case (kind)
			REQ_PUSH_R: begin
				if (occupancy == DEPTH) begin
					res.status = STATUS_FULL;
				end else begin
					ring_words[IDX_W'(head_idx + occupancy)] = value;
					occupancy++;
				end
			end
			REQ_POP_L, REQ_POP_R, REQ_PEEK_L, REQ_PEEK_R: begin
				if (occupancy == 0) begin
					res.status = STATUS_EMPTY;
				end else if (kind == REQ_POP_L || kind == REQ_PEEK_L) begin
					res.word = ring_words[head_idx];
					if (kind == REQ_POP_L) begin
						head_idx++;
						occupancy--;
					end
				end else begin
					res.word = ring_words[IDX_W'(head_idx + occupancy - 1)];
					if (kind == REQ_POP_R) begin
						occupancy--;
					end
				end
				if (occupancy == 0) begin
					head_idx = '0;
				end
			end
			default: begin
			end
		endcase
		res.empty = (occupancy == 0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		deq_result_t want;
		deq_result_t got;
		if (!arst_n) begin
			head_idx  = '0;
			occupancy = '0;
			outstanding_q.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.word   = m_tdata[VALUE_W-1:0];
				got.empty  = m_tdata[VALUE_W];
				got.status = m_tuser;
				results_seen++;
				if (outstanding_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("%t: unexpected item word=%h empty=%b status=%0d",
							$realtime, got.word, got.empty, got.status);
					end
				end else begin
					want = outstanding_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display({"%t: mismatch expected word=%h empty=%b status=%0d,",
								" got word=%h empty=%b status=%0d"},
								$realtime, want.word, want.empty, want.status,
								got.word, got.empty, got.status);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_request(s_tuser, s_tdata[VALUE_W-1:0], want);
				if (want.status == STATUS_EMPTY) begin
					empty_hits++;
				end
				if (want.status == STATUS_FULL) begin
					full_hits++;
				end
				outstanding_q = {outstanding_q, want};
			end
			pending = outstanding_q.size();
		end
	end

endmodule

// ----- dv/tb_double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push, pop and peek requests with random gaps and back-pressure: a
// short directed opening on the empty queue and the unused request codes,
// then phases that fill the ring past full, drain it past empty and mix all
// requests. A separate checker predicts and compares every returned item.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;

	timeunit 1ns;
	timeprecision 1ps;

	import deq_pkg::*;

	localparam int CAPACITY = 256;
	localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 3'd7;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
	logic [REQ_W-1:0]     s_axis_tuser  = REQ_PUSH_R;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]  m_axis_tuser;

	bit no_gaps = 1'b0;
	int sent    = 0;
	int fail_count, pending, results_seen, empty_hits, full_hits;

	double_ended_queue #(
		.CAPACITY  (CAPACITY),
		.WORD_WIDTH(VALUE_W)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	deq_checker #(
		.DEPTH(CAPACITY)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.s_tdata     (s_axis_tdata),
		.s_tuser     (s_axis_tuser),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.m_tuser     (m_axis_tuser),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen),
		.empty_hits  (empty_hits),
		.full_hits   (full_hits)
	);

	initial begin
		forever begin
			#10 clk = ~clk;
		end
	end

	initial begin
		#4_000_000;
		$display("tb_double_ended_queue: FAIL");
		$finish;
	end

	initial begin
		@(posedge clk);
		forever begin
			m_axis_tready <= no_gaps || ($urandom_range(99) >= 38);
			@(posedge clk);
		end
	end

	task automatic send_req(input logic [REQ_W-1:0] kind, input logic [S_TDATA_W-1:0] value);
		if (!no_gaps) begin
			while ($urandom_range(99) < 38) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tuser  <= kind;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		sent++;
	endtask

	function automatic logic [REQ_W-1:0] pick_req(input int mode);
		logic [REQ_W-1:0] kind;
		kind = REQ_UNKNOWN_HI;
		case (mode)
			0: begin
				if ($urandom_range(99) < 90) begin
					kind = REQ_PUSH_R;
				end else begin
					kind = REQ_W'($urandom_range(REQ_POP_L, REQ_UNKNOWN_HI));
				end
			end
			1: begin
				if ($urandom_range(99) < 90) begin
					kind = $urandom_range(1) ? REQ_POP_L : REQ_POP_R;
				end else begin
					kind = REQ_W'($urandom_range(REQ_PUSH_R, REQ_UNKNOWN_HI));
				end
			end
			default: begin
				kind = REQ_W'($urandom_range(REQ_PUSH_R, REQ_UNKNOWN_HI));
			end
		endcase
		return kind;
	endfunction

	initial begin
		int mode;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_req(REQ_PEEK_L, 32'h0000_0000);
		send_req(REQ_PEEK_R, 32'hFFFF_FFFF);
		send_req(REQ_POP_L, 32'h1234_5678);
		send_req(REQ_POP_R, 32'h8765_4321);
		send_req(REQ_UNKNOWN_LO, 32'hFFFF_FFFF);
		send_req(REQ_UNKNOWN_LO + 3'd1, 32'h0000_0000);
		send_req(REQ_UNKNOWN_HI, 32'hDEAD_BEEF);
		send_req(REQ_PUSH_R, 32'h0000_0000);
		send_req(REQ_PUSH_R, 32'hFFFF_FFFF);
		send_req(REQ_PUSH_R, 32'h5A5A_A5A5);
		send_req(REQ_UNKNOWN_HI, 32'h0000_0001);
		send_req(REQ_PEEK_L, 32'h0000_0000);
		send_req(REQ_PEEK_R, 32'h0000_0000);
		send_req(REQ_POP_R, 32'h0000_0000);
		send_req(REQ_POP_L, 32'h0000_0000);
		send_req(REQ_POP_L, 32'h0000_0000);
		send_req(REQ_PUSH_R, 32'h8000_0001);
		send_req(REQ_PEEK_L, 32'h0000_0000);
		send_req(REQ_PUSH_R, 32'h7FFF_FFFE);
		send_req(REQ_POP_L, 32'h0000_0000);
		send_req(REQ_POP_R, 32'h0000_0000);
		send_req(REQ_POP_L, 32'h0000_0000);

		for (int i = 0; i < 880; i++) begin
			mode = (i < 380) ? 0 : (i < 720) ? 1 : 2;
			no_gaps = (i >= 400 && i < 560);
			send_req(pick_req(mode), $urandom);
		end
		no_gaps = 1'b0;
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);

		$display("Sent %0d requests and checked %0d returned items.", sent, results_seen);
		$display("%0d requests met an empty queue and %0d pushes met a full one.",
			empty_hits, full_hits);
		if (fail_count == 0) begin
			$display("tb_double_ended_queue: PASS");
		end else begin
			$display("tb_double_ended_queue: FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_ctrl.sv
rtl/deq_datapath.sv
rtl/double_ended_queue.sv
rtl/deq_checker.sv
dv/deq_checker.sv
dv/tb_double_ended_queue.sv
